// File: sv/llm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llm_pkg
// Shared types and codes for the latency line memory.
// ----------------------------------------------------------------------------
package llm_pkg;

    localparam int unsigned WORD_W     = 16;
    localparam int unsigned ADDR_W     = 12;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned LAT_W      = 10;
    localparam int unsigned LINE_WORDS = 8;
    localparam int unsigned MEM_WORDS  = 4096;
    localparam int unsigned BANK_W     = $clog2(LINE_WORDS);
    localparam int unsigned ROWS       = MEM_WORDS / LINE_WORDS;
    localparam int unsigned ROW_W      = $clog2(ROWS);

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [TIME_W-1:0] time_t;
    typedef logic [LINE_WORDS-1:0][WORD_W-1:0] line_t;

    typedef struct packed {
        addr_t addr;
        time_t due;
    } rq_entry_t;

    typedef struct packed {
        addr_t addr;
        time_t due;
        line_t data;
    } wq_entry_t;

    typedef struct packed {
        logic             clear;
        logic             we;
        logic [ROW_W-1:0] clr_row;
        addr_t            base;
    } lane_ctrl_t;

    localparam logic [1:0] CMD_RD_REQ  = 2'd0;
    localparam logic [1:0] CMD_WR_REQ  = 2'd1;
    localparam logic [1:0] CMD_RD_POLL = 2'd2;
    localparam logic [1:0] CMD_WR_POLL = 2'd3;

    localparam logic [2:0] OUT_QUEUED     = 3'd0;
    localparam logic [2:0] OUT_REJECTED   = 3'd1;
    localparam logic [2:0] OUT_NONE       = 3'd2;
    localparam logic [2:0] OUT_READ_DATA  = 3'd3;
    localparam logic [2:0] OUT_WRITE_DONE = 3'd4;

    localparam logic REG_READ_LAT  = 1'b0;
    localparam logic REG_WRITE_LAT = 1'b1;

endpackage

// File: sv/latency_line_memory.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// latency_line_memory
// Line memory with read and write queues that retire requests once due.
// ----------------------------------------------------------------------------
// Requests, rejects, write polls and polls with nothing due pass through the
// lookup state only; a read poll that retires also passes through the fetch
// state (queue head lookup, then bank read). done pulses after the last state.
// The rate is set by the registered read of the queue and bank RAMs.
// After reset the banks are zeroed in a pass over all 512 rows with busy high.
// Results cannot be stalled; done lasts one cycle.
module latency_line_memory
    import llm_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [LAT_W-1:0]  cfg_data,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        command,
    input  logic [ADDR_W-1:0] line_address,
    input  logic [TIME_W-1:0] now,
    input  logic [WORD_W-1:0] in_word0,
    input  logic [WORD_W-1:0] in_word1,
    input  logic [WORD_W-1:0] in_word2,
    input  logic [WORD_W-1:0] in_word3,
    input  logic [WORD_W-1:0] in_word4,
    input  logic [WORD_W-1:0] in_word5,
    input  logic [WORD_W-1:0] in_word6,
    input  logic [WORD_W-1:0] in_word7,
    output logic              done,
    output logic [2:0]        outcome,
    output logic [ADDR_W-1:0] done_address,
    output logic [WORD_W-1:0] out_word0,
    output logic [WORD_W-1:0] out_word1,
    output logic [WORD_W-1:0] out_word2,
    output logic [WORD_W-1:0] out_word3,
    output logic [WORD_W-1:0] out_word4,
    output logic [WORD_W-1:0] out_word5,
    output logic [WORD_W-1:0] out_word6,
    output logic [WORD_W-1:0] out_word7
);

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_LOOK  = 2'd2;
    localparam logic [1:0] ST_FETCH = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [ROW_W-1:0] clr_row_reg, clr_row_next;
    logic [PTR_W-1:0] rd_head_reg, rd_head_next, rd_tail_reg, rd_tail_next;
    logic [PTR_W-1:0] wr_head_reg, wr_head_next, wr_tail_reg, wr_tail_next;
    logic [CNT_W-1:0] rd_count_reg, rd_count_next, wr_count_reg, wr_count_next;
    logic [LAT_W-1:0] rd_lat_reg, rd_lat_next, wr_lat_reg, wr_lat_next;
    logic             done_reg, done_next;

    logic [1:0]       cmd_reg;
    addr_t            addr_reg;
    time_t            now_reg;
    line_t            in_line_reg;
    addr_t            line_addr_reg, line_addr_next;
    logic [2:0]       outcome_reg, outcome_next;
    addr_t            done_addr_reg, done_addr_next;
    line_t            out_line_reg, out_line_next;

    logic             accept;
    logic             rq_we, wq_we;
    rq_entry_t        rq_wdata, rq_rdata;
    wq_entry_t        wq_wdata, wq_rdata;
    lane_ctrl_t       lane_ctrl;
    line_t            bank_data;
    line_t            merged;

    assign busy   = state_reg != ST_IDLE;
    assign accept = start && !busy;

    // ---- request queues ----
    assign rq_wdata.addr = addr_reg;
    assign rq_wdata.due  = now_reg + TIME_W'(rd_lat_reg);
    assign wq_wdata.addr = addr_reg;
    assign wq_wdata.due  = now_reg + TIME_W'(wr_lat_reg);
    assign wq_wdata.data = in_line_reg;

    llm_ram #(
        .WIDTH ($bits(rq_entry_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_rd_queue (
        .clk   (clk),
        .we    (rq_we),
        .waddr (rd_tail_reg),
        .wdata (rq_wdata),
        .raddr (rd_head_reg),
        .rdata (rq_rdata)
    );

    llm_ram #(
        .WIDTH ($bits(wq_entry_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_wr_queue (
        .clk   (clk),
        .we    (wq_we),
        .waddr (wr_tail_reg),
        .wdata (wq_wdata),
        .raddr (wr_head_reg),
        .rdata (wq_rdata)
    );

    // ---- memory lanes ----
    for (genvar g = 0; g < LINE_WORDS; g++)
    begin : g_lane
        llm_lane #(
            .LANE (g)
        ) u_lane (
            .clk   (clk),
            .ctrl  (lane_ctrl),
            .line  (wq_rdata.data),
            .rdata (bank_data[g])
        );
    end

    llm_merge u_merge (
        .bank_data (bank_data),
        .base_low  (line_addr_reg[BANK_W-1:0]),
        .line      (merged)
    );

    // ---- control ----
    always_comb
    begin
        state_next     = state_reg;
        clr_row_next   = clr_row_reg;
        rd_head_next   = rd_head_reg;
        rd_tail_next   = rd_tail_reg;
        rd_count_next  = rd_count_reg;
        wr_head_next   = wr_head_reg;
        wr_tail_next   = wr_tail_reg;
        wr_count_next  = wr_count_reg;
        rd_lat_next    = rd_lat_reg;
        wr_lat_next    = wr_lat_reg;
        done_next      = 1'b0;
        outcome_next   = outcome_reg;
        done_addr_next = done_addr_reg;
        out_line_next  = out_line_reg;
        line_addr_next = line_addr_reg;
        rq_we          = 1'b0;
        wq_we          = 1'b0;
        lane_ctrl.clear   = 1'b0;
        lane_ctrl.we      = 1'b0;
        lane_ctrl.clr_row = clr_row_reg;
        lane_ctrl.base    = rq_rdata.addr;

        case (state_reg)
            ST_CLEAR:
            begin
                lane_ctrl.clear = 1'b1;
                if (clr_row_reg == ROW_W'(ROWS - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_row_next = clr_row_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                state_next     = ST_IDLE;
                done_next      = 1'b1;
                done_addr_next = '0;
                out_line_next  = '0;
                outcome_next   = OUT_NONE;
                case (cmd_reg)
                    CMD_RD_REQ:
                    begin
                        if (rd_count_reg == CNT_W'(QUEUE_DEPTH))
                        begin
                            outcome_next = OUT_REJECTED;
                        end
                        else
                        begin
                            rq_we         = 1'b1;
                            rd_tail_next  = (rd_tail_reg == PTR_W'(QUEUE_DEPTH - 1)) ?
                                            '0 : rd_tail_reg + 1'b1;
                            rd_count_next = rd_count_reg + 1'b1;
                            outcome_next  = OUT_QUEUED;
                        end
                    end
                    CMD_WR_REQ:
                    begin
                        if (wr_count_reg == CNT_W'(QUEUE_DEPTH))
                        begin
                            outcome_next = OUT_REJECTED;
                        end
                        else
                        begin
                            wq_we         = 1'b1;
                            wr_tail_next  = (wr_tail_reg == PTR_W'(QUEUE_DEPTH - 1)) ?
                                            '0 : wr_tail_reg + 1'b1;
                            wr_count_next = wr_count_reg + 1'b1;
                            outcome_next  = OUT_QUEUED;
                        end
                    end
                    CMD_RD_POLL:
                    begin
                        if (rd_count_reg != '0 && rq_rdata.due <= now_reg)
                        begin
                            done_next      = 1'b0;
                            state_next     = ST_FETCH;
                            line_addr_next = rq_rdata.addr;
                            rd_head_next   = (rd_head_reg == PTR_W'(QUEUE_DEPTH - 1)) ?
                                             '0 : rd_head_reg + 1'b1;
                            rd_count_next  = rd_count_reg - 1'b1;
                        end
                    end
                    default:
                    begin
                        if (wr_count_reg != '0 && wq_rdata.due <= now_reg)
                        begin
                            lane_ctrl.we   = 1'b1;
                            lane_ctrl.base = wq_rdata.addr;
                            outcome_next   = OUT_WRITE_DONE;
                            done_addr_next = wq_rdata.addr;
                            wr_head_next   = (wr_head_reg == PTR_W'(QUEUE_DEPTH - 1)) ?
                                             '0 : wr_head_reg + 1'b1;
                            wr_count_next  = wr_count_reg - 1'b1;
                        end
                    end
                endcase
            end
            ST_FETCH:
            begin
                state_next     = ST_IDLE;
                done_next      = 1'b1;
                outcome_next   = OUT_READ_DATA;
                done_addr_next = line_addr_reg;
                out_line_next  = merged;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            if (cfg_index == REG_READ_LAT)
            begin
                rd_lat_next = cfg_data;
            end
            else
            begin
                wr_lat_next = cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_row_reg  <= '0;
            rd_head_reg  <= '0;
            rd_tail_reg  <= '0;
            rd_count_reg <= '0;
            wr_head_reg  <= '0;
            wr_tail_reg  <= '0;
            wr_count_reg <= '0;
            rd_lat_reg   <= LAT_W'(10);
            wr_lat_reg   <= LAT_W'(10);
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_row_reg  <= clr_row_next;
            rd_head_reg  <= rd_head_next;
            rd_tail_reg  <= rd_tail_next;
            rd_count_reg <= rd_count_next;
            wr_head_reg  <= wr_head_next;
            wr_tail_reg  <= wr_tail_next;
            wr_count_reg <= wr_count_next;
            rd_lat_reg   <= rd_lat_next;
            wr_lat_reg   <= wr_lat_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg     <= command;
            addr_reg    <= line_address;
            now_reg     <= now;
            in_line_reg <= {in_word7, in_word6, in_word5, in_word4,
                            in_word3, in_word2, in_word1, in_word0};
        end
        line_addr_reg <= line_addr_next;
        outcome_reg   <= outcome_next;
        done_addr_reg <= done_addr_next;
        out_line_reg  <= out_line_next;
    end

    assign done         = done_reg;
    assign outcome      = outcome_reg;
    assign done_address = done_addr_reg;
    assign out_word0    = out_line_reg[0];
    assign out_word1    = out_line_reg[1];
    assign out_word2    = out_line_reg[2];
    assign out_word3    = out_line_reg[3];
    assign out_word4    = out_line_reg[4];
    assign out_word5    = out_line_reg[5];
    assign out_word6    = out_line_reg[6];
    assign out_word7    = out_line_reg[7];

    // ---- checks ----
    a_rd_count: assert property (@(posedge clk) disable iff (!rst_n)
        rd_count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("read queue count overflow");

    a_wr_count: assert property (@(posedge clk) disable iff (!rst_n)
        wr_count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("write queue count overflow");

    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(state_reg) == ST_LOOK || $past(state_reg) == ST_FETCH))
        else $error("result strobe without a request in flight");

    a_read_src: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && outcome_reg == OUT_READ_DATA) |-> $past(state_reg) == ST_FETCH)
        else $error("read data returned without a bank fetch");

    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> (!done_reg && rd_count_reg == '0 && wr_count_reg == '0))
        else $error("activity during clearing pass");

endmodule

// File: sv/llm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llm_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module llm_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// File: sv/llm_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llm_lane
// One memory bank with its row and word steering for a line access.
// ----------------------------------------------------------------------------
module llm_lane
    import llm_pkg::*;
#(
    parameter int unsigned LANE = 0
) (
    input  logic       clk,
    input  lane_ctrl_t ctrl,
    input  line_t      line,
    output word_t      rdata
);

    logic [BANK_W-1:0] lane_id;
    logic [BANK_W-1:0] offset;
    logic              carry;
    logic [ROW_W-1:0]  row;
    logic [ROW_W-1:0]  waddr;
    word_t             wdata;
    logic              we;

    // word of the line that falls in this bank, and the row it sits in
    assign lane_id = BANK_W'(LANE);
    assign offset  = lane_id - ctrl.base[BANK_W-1:0];
    assign carry   = lane_id < ctrl.base[BANK_W-1:0];
    assign row     = ctrl.base[ADDR_W-1:BANK_W] + {{(ROW_W-1){1'b0}}, carry};

    assign we    = ctrl.clear | ctrl.we;
    assign waddr = ctrl.clear ? ctrl.clr_row : row;
    assign wdata = ctrl.clear ? '0 : line[offset];

    llm_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ROWS)
    ) u_bank (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (row),
        .rdata (rdata)
    );

endmodule

// File: sv/llm_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llm_merge
// Rotates the bank outputs back into line word order.
// ----------------------------------------------------------------------------
module llm_merge
    import llm_pkg::*;
(
    input  line_t             bank_data,
    input  logic [BANK_W-1:0] base_low,
    output line_t             line
);

    always_comb
    begin
        for (int i = 0; i < LINE_WORDS; i++)
        begin
            line[i] = bank_data[BANK_W'(base_low + BANK_W'(i))];
        end
    end

endmodule
